FILE: rtl/core/cqdi_pkg.sv
package cqdi_pkg;

	localparam int DATA_W           = 64;
	localparam int COUNT_W          = 4;
	localparam int RESULT_W         = 32;
	localparam int DATA_FIELD_BYTES = 8;

	localparam int WORD_BYTES_DEF  = 8;
	localparam int OFFSET_BITS_DEF = 32;

	localparam logic [7:0] QUOTE_BYTE     = 8'h22;
	localparam logic [7:0] NEWLINE_BYTE   = 8'h0A;
	localparam logic [7:0] SEPARATOR_INIT = 8'd44;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_EMIT
	} cqdi_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic advance;
	} cqdi_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic word_hits;
		logic last_hit;
	} cqdi_status_t;

endpackage

FILE: rtl/core/cqdi_if.sv
interface cqdi_in_if;
	logic                            valid;
	logic                            ready;
	logic                            start_of_buffer;
	logic [cqdi_pkg::DATA_W-1:0]     data_bytes;
	logic [cqdi_pkg::COUNT_W-1:0]    valid_bytes;

	modport source (output valid, output start_of_buffer, output data_bytes,
		output valid_bytes, input ready);
	modport sink (input valid, input start_of_buffer, input data_bytes,
		input valid_bytes, output ready);
endinterface

interface cqdi_out_if;
	logic                            valid;
	logic                            ready;
	logic [cqdi_pkg::RESULT_W-1:0]   delimiter_position;
	logic [cqdi_pkg::RESULT_W-1:0]   delimiter_ordinal;
	logic                            last_of_word;

	modport source (output valid, output delimiter_position, output delimiter_ordinal,
		output last_of_word, input ready);
	modport sink (input valid, input delimiter_position, input delimiter_ordinal,
		input last_of_word, output ready);
endinterface

FILE: rtl/core/cqdi_ctrl.sv
module cqdi_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  out_ready,
	input  cqdi_pkg::cqdi_status_t status,
	output cqdi_pkg::cqdi_cmd_t    cmd,
	output logic                  in_ready,
	output logic                  out_valid
);
	import cqdi_pkg::*;

	cqdi_state_t state_q;
	cqdi_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.load && status.word_hits) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (cmd.advance && status.last_hit) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ready  = 1'b1;
			ST_EMIT: out_valid = 1'b1;
			default: ;
		endcase
		cmd.load    = in_valid && in_ready;
		cmd.advance = out_valid && out_ready;
	end

endmodule

FILE: rtl/core/cqdi_datapath.sv
module cqdi_datapath #(
	parameter int WORD_BYTES  = cqdi_pkg::WORD_BYTES_DEF,
	parameter int OFFSET_BITS = cqdi_pkg::OFFSET_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [7:0]                        cfg_wr_data,
	input  cqdi_pkg::cqdi_cmd_t               cmd,
	input  logic                              start_of_buffer,
	input  logic [cqdi_pkg::DATA_W-1:0]       data_bytes,
	input  logic [cqdi_pkg::COUNT_W-1:0]      valid_bytes,
	output cqdi_pkg::cqdi_status_t            status,
	output logic [cqdi_pkg::RESULT_W-1:0]     delimiter_position,
	output logic [cqdi_pkg::RESULT_W-1:0]     delimiter_ordinal,
	output logic                              last_of_word
);
	import cqdi_pkg::*;

	localparam int LANES = (WORD_BYTES < DATA_FIELD_BYTES) ? WORD_BYTES : DATA_FIELD_BYTES;
	localparam int IDX_W = (LANES > 1) ? $clog2(LANES) : 1;

	logic [7:0]             sep_q;
	logic                   quote_q;
	logic [OFFSET_BITS-1:0] offset_q;
	logic [RESULT_W-1:0]    total_q;
	logic [LANES-1:0]       mask_q;
	logic [OFFSET_BITS-1:0] word_base_q;

	logic [COUNT_W-1:0]     count;
	logic [OFFSET_BITS-1:0] base_off;
	logic                   quote_in;
	logic                   quote_out;
	logic [LANES-1:0]       hit;
	logic [LANES-1:0]       mask_rest;
	logic [IDX_W-1:0]       hit_idx;
	logic [OFFSET_BITS-1:0] pos_full;

	assign count    = (valid_bytes > COUNT_W'(LANES)) ? COUNT_W'(LANES) : valid_bytes;
	assign base_off = start_of_buffer ? '0 : offset_q;
	assign quote_in = start_of_buffer ? 1'b0 : quote_q;

	// quote state runs as a prefix XOR across the live lanes
	always_comb begin
		logic       q;
		logic [7:0] b;
		logic       live;
		q   = quote_in;
		hit = '0;
		for (int i = 0; i < LANES; i++) begin
			b    = data_bytes[8*i +: 8];
			live = COUNT_W'(i) < count;
			if (live && b == QUOTE_BYTE) begin
				q = ~q;
			end
			hit[i] = live && !q && (b == sep_q || b == NEWLINE_BYTE);
		end
		quote_out = q;
	end

	always_comb begin
		hit_idx = '0;
		for (int i = LANES - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				hit_idx = IDX_W'(i);
			end
		end
	end

	assign mask_rest = mask_q & (mask_q - LANES'(1));
	assign pos_full  = word_base_q + OFFSET_BITS'(hit_idx);

	assign delimiter_position = RESULT_W'(pos_full);
	assign delimiter_ordinal  = total_q;
	assign last_of_word       = (mask_rest == '0);

	assign status.word_hits = |hit;
	assign status.last_hit  = (mask_rest == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_q    <= SEPARATOR_INIT;
			quote_q  <= 1'b0;
			offset_q <= '0;
			total_q  <= '0;
		end else begin
			if (cfg_wr_en) begin
				sep_q <= cfg_wr_data;
			end
			if (cmd.load) begin
				quote_q  <= quote_out;
				offset_q <= base_off + OFFSET_BITS'(count);
				if (start_of_buffer) begin
					total_q <= '0;
				end
			end else if (cmd.advance) begin
				total_q <= total_q + RESULT_W'(1);
			end
		end
	end

	// one set bit per delimiter still to be sent for the held word
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mask_q      <= hit;
			word_base_q <= base_off;
		end else if (cmd.advance) begin
			mask_q <= mask_rest;
		end
	end

endmodule

FILE: rtl/core/csv_quoted_delimiter_indexer_core.sv
// Finds every separator or newline byte outside a quoted region in a CSV stream
// taken eight bytes to a word, and sends one result word per delimiter in byte
// order, carrying its absolute byte offset, its running number since buffer start
// and a flag on the last one of the input word. Quote state, offset and count carry
// across words; start_of_buffer clears them ahead of its word. A word without
// delimiters leaves the block idle; a word with delimiters has its held mask
// drained one result per cycle while delims.ready is high, and the next word is
// taken only once the last result of the current word has been accepted. The
// separator register may be written only while no word is in progress.
module csv_quoted_delimiter_indexer_core #(
	parameter int WORD_BYTES  = cqdi_pkg::WORD_BYTES_DEF,
	parameter int OFFSET_BITS = cqdi_pkg::OFFSET_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	cqdi_in_if.sink    words,
	cqdi_out_if.source delims
);
	import cqdi_pkg::*;

	cqdi_cmd_t    cmd;
	cqdi_status_t status;

	cqdi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (words.valid),
		.out_ready (delims.ready),
		.status    (status),
		.cmd       (cmd),
		.in_ready  (words.ready),
		.out_valid (delims.valid)
	);

	cqdi_datapath #(
		.WORD_BYTES  (WORD_BYTES),
		.OFFSET_BITS (OFFSET_BITS)
	) u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_wr_en          (cfg_wr_en),
		.cfg_wr_data        (cfg_wr_data),
		.cmd                (cmd),
		.start_of_buffer    (words.start_of_buffer),
		.data_bytes         (words.data_bytes),
		.valid_bytes        (words.valid_bytes),
		.status             (status),
		.delimiter_position (delims.delimiter_position),
		.delimiter_ordinal  (delims.delimiter_ordinal),
		.last_of_word       (delims.last_of_word)
	);

endmodule

FILE: rtl/core/cqdi_checker.sv
module cqdi_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [cqdi_pkg::RESULT_W-1:0] delimiter_position,
	input logic [cqdi_pkg::RESULT_W-1:0] delimiter_ordinal,
	input logic                          last_of_word
);
	import cqdi_pkg::*;

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(delimiter_position)
			&& $stable(delimiter_ordinal) && $stable(last_of_word))
		else $error("result word changed while stalled");

	// no new input word while results of the current one are pending
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken while results pending");

	// idle with nothing offered stays idle
	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && !in_valid |=> in_ready)
		else $error("left idle without an input word");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_of_word |=> !out_valid)
		else $error("result after last of word");

	a_ordinal_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_word |=> out_valid
			&& delimiter_ordinal == $past(delimiter_ordinal) + RESULT_W'(1))
		else $error("ordinal did not advance within word");

endmodule

bind csv_quoted_delimiter_indexer_core cqdi_checker u_cqdi_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.in_valid           (words.valid),
	.in_ready           (words.ready),
	.out_valid          (delims.valid),
	.out_ready          (delims.ready),
	.delimiter_position (delims.delimiter_position),
	.delimiter_ordinal  (delims.delimiter_ordinal),
	.last_of_word       (delims.last_of_word)
);
